// ----- rtl/pwce_pkg.sv -----
// Shared types, constants and the helper function of the priority write cache engine.
`timescale 1ns / 1ps

package pwce_pkg;

    localparam int DEPTH        = 32;
    localparam int DISK_SECTORS = 4096;
    localparam int IDX_W        = $clog2(DEPTH);
    localparam int CNT_W        = $clog2(DEPTH + 1);
    localparam int EVICT_FACTOR = 3;
    localparam int LIMIT_RESET  = 128;

    localparam int OWNER_W = 22;
    localparam int PRIO_W  = 16;
    localparam int SEC_W   = 12;
    localparam int LEN_W   = 9;
    localparam int TOT_W   = 14;
    localparam int DW_W    = 32;
    localparam int LIM_W   = 11;
    localparam int ACT_W   = 3;

    localparam int IN_TDATA_W  = 64;
    localparam int OUT_TDATA_W = 96;

    // Action codes of a request.
    localparam logic [ACT_W-1:0] ACT_WRITE     = 3'd0;
    localparam logic [ACT_W-1:0] ACT_READ      = 3'd1;
    localparam logic [ACT_W-1:0] ACT_FLUSH_OWN = 3'd2;
    localparam logic [ACT_W-1:0] ACT_FLUSH_ALL = 3'd3;
    localparam logic [ACT_W-1:0] ACT_DRAIN     = 3'd4;
    localparam logic [ACT_W-1:0] ACT_LIMIT     = 3'd5;

    typedef enum logic [1:0] {
        K_FLUSH = 2'd0,
        K_WT    = 2'd1,
        K_READ  = 2'd2,
        K_DONE  = 2'd3
    } t_kind;

    typedef struct packed {
        logic [OWNER_W-1:0] owner;
        logic [PRIO_W-1:0]  prio;
        logic [SEC_W-1:0]   sector;
        logic [LEN_W-1:0]   len;
    } t_entry;

    // Per-cell move control.
    typedef struct packed {
        logic take_right;
        logic take_left;
        logic load_new;
    } t_cell_ctl;

    // Row-level operation requested by the sequencer.
    typedef struct packed {
        logic             remove;
        logic [IDX_W-1:0] rm_idx;
        logic             insert;
    } t_chain_op;

    // Clip a range to the end of the disk.
    function automatic logic [LEN_W-1:0] clip_len(input logic [SEC_W-1:0] sec,
                                                  input logic [LEN_W-1:0] n);
        logic [16:0] room;
        logic [LEN_W-1:0] res;
        room = 17'(DISK_SECTORS) - 17'(sec);
        if (17'(sec) >= 17'(DISK_SECTORS)) begin
            res = '0;
        end else if (17'(n) < room) begin
            res = n;
        end else begin
            res = LEN_W'(room);
        end
        return res;
    endfunction

endpackage

// ----- rtl/pwce_cell.sv -----
// One table cell: holds one cached entry and moves it to or from its neighbors.
`timescale 1ns / 1ps

module pwce_cell (
    input  logic              i_clk,
    input  pwce_pkg::t_cell_ctl i_ctl,
    input  pwce_pkg::t_entry  i_left,
    input  pwce_pkg::t_entry  i_right,
    input  pwce_pkg::t_entry  i_new,
    output pwce_pkg::t_entry  o_ent,
    output logic              o_le
);

    pwce_pkg::t_entry r_ent;

    always_ff @(posedge i_clk) begin
        if (i_ctl.take_right) begin
            r_ent <= i_right;
        end else if (i_ctl.load_new) begin
            r_ent <= i_new;
        end else if (i_ctl.take_left) begin
            r_ent <= i_left;
        end
    end

    // The new entry goes behind every entry with an equal or lower value.
    assign o_le  = (r_ent.prio <= i_new.prio);
    assign o_ent = r_ent;

endmodule

// ----- rtl/pwce_chain.sv -----
// Row of table cells with the per-cell shift control for remove and sorted insert.
`timescale 1ns / 1ps

module pwce_chain (
    input  logic                        i_clk,
    input  pwce_pkg::t_chain_op         i_op,
    input  pwce_pkg::t_entry            i_new,
    input  logic [pwce_pkg::CNT_W-1:0]  i_count,
    output pwce_pkg::t_entry            o_ent [pwce_pkg::DEPTH]
);

    pwce_pkg::t_cell_ctl ctl   [pwce_pkg::DEPTH];
    logic                le    [pwce_pkg::DEPTH];
    logic                ahead [pwce_pkg::DEPTH];

    genvar k;
    generate
        for (k = 0; k < pwce_pkg::DEPTH; k++) begin : g_cell
            pwce_pkg::t_entry left_ent;
            pwce_pkg::t_entry right_ent;

            if (k == 0) begin : g_first
                assign left_ent = i_new;
            end else begin : g_mid
                assign left_ent = o_ent[k-1];
            end
            if (k == pwce_pkg::DEPTH - 1) begin : g_last
                assign right_ent = o_ent[k];
            end else begin : g_inner
                assign right_ent = o_ent[k+1];
            end

            assign ahead[k] = (pwce_pkg::CNT_W'(k) < i_count) && le[k];

            always_comb begin
                ctl[k] = '0;
                if (i_op.remove) begin
                    ctl[k].take_right = (pwce_pkg::IDX_W'(k) >= i_op.rm_idx);
                end else if (i_op.insert && !ahead[k]) begin
                    if (k == 0) begin
                        ctl[k].load_new = 1'b1;
                    end else if (ahead[(k == 0) ? 0 : k-1]) begin
                        ctl[k].load_new = 1'b1;
                    end else begin
                        ctl[k].take_left = 1'b1;
                    end
                end
            end

            pwce_cell u_cell (
                .i_clk   (i_clk),
                .i_ctl   (ctl[k]),
                .i_left  (left_ent),
                .i_right (right_ent),
                .i_new   (i_new),
                .o_ent   (o_ent[k]),
                .o_le    (le[k])
            );
        end
    endgenerate

endmodule

// ----- rtl/priority_write_cache_engine.sv -----
// Top level of the priority write cache engine: request sequencer, counters and result register.
// Requests are handled one at a time: after acceptance the sequencer flushes or skips entries
// one by one, takes a decision per phase and sends write-through, read-served and request-done
// transactions; the next request is taken the cycle after the request-done transaction is
// loaded into the result register, and result stalls hold the sequencer.
// Reset (synchronous, active low) empties the table, clears the counters and sets the limit to 128.
`timescale 1ns / 1ps

module priority_write_cache_engine (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Configuration: cache limit in sectors.
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [10:0]                        i_cfg_data,
    // Request stream. tdata from bit 0 up: owner[21:0], priority_req[37:22],
    // first_sector[49:38], sector_count[58:50], zero fill[63:59].
    // tuser holds action[2:0].
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    input  logic [pwce_pkg::IN_TDATA_W-1:0]    i_s_tdata,
    input  logic [pwce_pkg::ACT_W-1:0]         i_s_tuser,
    // Result stream. tdata from bit 0 up: flush_owner[21:0], flush_sector[33:22],
    // flush_count[42:34], cached_total[56:43], disk_writes[88:57], zero fill[95:89].
    // tuser holds kind[1:0]; tlast marks the final result of a request.
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    output logic [pwce_pkg::OUT_TDATA_W-1:0]   o_m_tdata,
    output logic [1:0]                         o_m_tuser,
    output logic                               o_m_tlast
);

    // Sequencer states, one-hot.
    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_EVICT = 9'b000000010,
        S_SCAN  = 9'b000000100,
        S_WT    = 9'b000001000,
        S_READ  = 9'b000010000,
        S_FULL  = 9'b000100000,
        S_INS   = 9'b001000000,
        S_HEAD  = 9'b010000000,
        S_DONE  = 9'b100000000
    } t_state;

    // Which entries a scan flushes.
    typedef enum logic [1:0] {
        M_ALL   = 2'd0,
        M_OWNER = 2'd1,
        M_RANGE = 2'd2
    } t_mode;

    t_state r_state, n_state;
    t_state r_post, n_post;
    t_mode  r_mode, n_mode;

    logic [pwce_pkg::CNT_W-1:0]   r_cnt, n_cnt;
    logic [pwce_pkg::CNT_W-1:0]   r_idx, n_idx;
    logic [pwce_pkg::TOT_W-1:0]   r_cached, n_cached;
    logic [pwce_pkg::DW_W-1:0]    r_wc, n_wc;
    logic [pwce_pkg::LIM_W-1:0]   r_limit;
    logic [14:0]                  r_freed, n_freed;
    logic [16:0]                  r_target, n_target;

    // Latched request fields.
    logic [pwce_pkg::OWNER_W-1:0] r_own;
    logic [pwce_pkg::PRIO_W-1:0]  r_prio;
    logic [pwce_pkg::SEC_W-1:0]   r_sec;
    logic [pwce_pkg::LEN_W-1:0]   r_n;

    // Result register.
    logic                         r_ovalid;
    pwce_pkg::t_kind              r_okind;
    logic [pwce_pkg::OWNER_W-1:0] r_oown;
    logic [pwce_pkg::SEC_W-1:0]   r_osec;
    logic [pwce_pkg::LEN_W-1:0]   r_ocnt;
    logic [pwce_pkg::TOT_W-1:0]   r_otot;
    logic [pwce_pkg::DW_W-1:0]    r_odw;
    logic                         r_olast;

    logic                         emit;
    pwce_pkg::t_kind              e_kind;
    logic [pwce_pkg::OWNER_W-1:0] e_own;
    logic [pwce_pkg::SEC_W-1:0]   e_sec;
    logic [pwce_pkg::LEN_W-1:0]   e_cnt;
    logic                         e_last;

    pwce_pkg::t_entry    ent [pwce_pkg::DEPTH];
    pwce_pkg::t_entry    new_ent;
    pwce_pkg::t_entry    sel;
    pwce_pkg::t_chain_op op;
    logic                do_fl;
    logic [pwce_pkg::IDX_W-1:0] fidx;
    logic                out_free;
    logic                s_acc;
    logic                match;

    logic [pwce_pkg::ACT_W-1:0]   in_act;
    logic [pwce_pkg::OWNER_W-1:0] in_own;
    logic [pwce_pkg::PRIO_W-1:0]  in_prio;
    logic [pwce_pkg::SEC_W-1:0]   in_sec;
    logic [pwce_pkg::LEN_W-1:0]   in_n;
    logic [14:0]                  in_sum;

    assign in_act  = i_s_tuser;
    assign in_own  = i_s_tdata[21:0];
    assign in_prio = i_s_tdata[37:22];
    assign in_sec  = i_s_tdata[49:38];
    assign in_n    = i_s_tdata[58:50];
    assign in_sum  = 15'(r_cached) + 15'(in_n);

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = (r_state == S_IDLE);
    assign s_acc       = i_s_tvalid && o_s_tready;
    assign out_free    = !r_ovalid || i_m_tready;

    assign new_ent.owner  = r_own;
    assign new_ent.prio   = r_prio;
    assign new_ent.sector = r_sec;
    assign new_ent.len    = r_n;

    // Entry under the scan pointer. The pointer stays at the head outside a scan, so head
    // flushes see the head entry; it is only used while below the fill count.
    assign sel = ent[r_idx[pwce_pkg::IDX_W-1:0]];

    always_comb begin
        unique case (r_mode)
            M_ALL:   match = 1'b1;
            M_OWNER: match = (sel.owner == r_own);
            M_RANGE: match = ((13'(sel.sector) + 13'(sel.len)) > 13'(r_sec)) &&
                             (13'(sel.sector) < (13'(r_sec) + 13'(r_n)));
            default: match = 1'b0;
        endcase
    end

    always_comb begin
        n_state  = r_state;
        n_post   = r_post;
        n_mode   = r_mode;
        n_cnt    = r_cnt;
        n_idx    = r_idx;
        n_cached = r_cached;
        n_wc     = r_wc;
        n_freed  = r_freed;
        n_target = r_target;
        do_fl    = 1'b0;
        fidx     = '0;
        emit     = 1'b0;
        e_kind   = pwce_pkg::K_DONE;
        e_own    = '0;
        e_sec    = '0;
        e_cnt    = '0;
        e_last   = 1'b0;
        op       = '0;

        unique case (r_state)
            S_IDLE: begin
                if (s_acc) begin
                    n_idx = '0;
                    unique case (in_act)
                        pwce_pkg::ACT_WRITE: begin
                            n_freed = '0;
                            if (in_sum > 15'(r_limit)) begin
                                n_target = 17'(pwce_pkg::EVICT_FACTOR) *
                                           17'(in_sum - 15'(r_limit));
                            end else begin
                                n_target = '0;
                            end
                            n_state = S_EVICT;
                        end
                        pwce_pkg::ACT_READ: begin
                            n_mode  = M_RANGE;
                            n_post  = S_READ;
                            n_state = S_SCAN;
                        end
                        pwce_pkg::ACT_FLUSH_OWN: begin
                            n_mode  = M_OWNER;
                            n_post  = S_DONE;
                            n_state = S_SCAN;
                        end
                        pwce_pkg::ACT_FLUSH_ALL: begin
                            n_mode  = M_ALL;
                            n_post  = S_DONE;
                            n_state = S_SCAN;
                        end
                        pwce_pkg::ACT_DRAIN: begin
                            n_state = S_HEAD;
                        end
                        pwce_pkg::ACT_LIMIT: begin
                            n_mode  = M_ALL;
                            n_post  = S_DONE;
                            n_state = (r_cached > pwce_pkg::TOT_W'(r_limit)) ? S_SCAN : S_DONE;
                        end
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_EVICT: begin
                if (r_cnt != '0 && 17'(r_freed) < r_target) begin
                    if (out_free) begin
                        do_fl   = 1'b1;
                        n_freed = r_freed + 15'(sel.len);
                    end
                end else if (11'(r_n) > r_limit) begin
                    n_mode  = M_ALL;
                    n_post  = S_WT;
                    n_idx   = '0;
                    n_state = S_SCAN;
                end else begin
                    n_state = S_FULL;
                end
            end
            S_SCAN: begin
                if (r_idx >= r_cnt) begin
                    n_state = r_post;
                end else if (match) begin
                    if (out_free) begin
                        do_fl = 1'b1;
                        fidx  = r_idx[pwce_pkg::IDX_W-1:0];
                    end
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_WT: begin
                if (out_free) begin
                    n_wc    = r_wc + 1'b1;
                    emit    = 1'b1;
                    e_kind  = pwce_pkg::K_WT;
                    e_own   = r_own;
                    e_sec   = r_sec;
                    e_cnt   = pwce_pkg::clip_len(r_sec, r_n);
                    n_state = S_DONE;
                end
            end
            S_READ: begin
                if (out_free) begin
                    emit    = 1'b1;
                    e_kind  = pwce_pkg::K_READ;
                    e_own   = r_own;
                    e_sec   = r_sec;
                    e_cnt   = pwce_pkg::clip_len(r_sec, r_n);
                    n_state = S_DONE;
                end
            end
            S_FULL: begin
                if (r_cnt >= pwce_pkg::CNT_W'(pwce_pkg::DEPTH)) begin
                    if (out_free) begin
                        do_fl   = 1'b1;
                        n_state = S_INS;
                    end
                end else begin
                    n_state = S_INS;
                end
            end
            S_INS: begin
                op.insert = 1'b1;
                n_cnt     = r_cnt + 1'b1;
                n_cached  = r_cached + pwce_pkg::TOT_W'(r_n);
                n_state   = S_DONE;
            end
            S_HEAD: begin
                if (r_cnt != '0) begin
                    if (out_free) begin
                        do_fl   = 1'b1;
                        n_state = S_DONE;
                    end
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    emit    = 1'b1;
                    e_kind  = pwce_pkg::K_DONE;
                    e_last  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        // A flush removes the selected entry, counts a disk write and sends its record.
        if (do_fl) begin
            op.remove = 1'b1;
            op.rm_idx = fidx;
            n_cnt     = r_cnt - 1'b1;
            n_wc      = r_wc + 1'b1;
            n_cached  = (r_cached >= pwce_pkg::TOT_W'(sel.len)) ?
                        r_cached - pwce_pkg::TOT_W'(sel.len) : '0;
            emit      = 1'b1;
            e_kind    = pwce_pkg::K_FLUSH;
            e_own     = sel.owner;
            e_sec     = sel.sector;
            e_cnt     = pwce_pkg::clip_len(sel.sector, sel.len);
        end
    end

    pwce_chain u_chain (
        .i_clk   (i_clk),
        .i_op    (op),
        .i_new   (new_ent),
        .i_count (r_cnt),
        .o_ent   (ent)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_post   <= S_DONE;
            r_mode   <= M_ALL;
            r_cnt    <= '0;
            r_idx    <= '0;
            r_cached <= '0;
            r_wc     <= '0;
            r_freed  <= '0;
            r_target <= '0;
            r_limit  <= pwce_pkg::LIM_W'(pwce_pkg::LIMIT_RESET);
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_post   <= n_post;
            r_mode   <= n_mode;
            r_cnt    <= n_cnt;
            r_idx    <= n_idx;
            r_cached <= n_cached;
            r_wc     <= n_wc;
            r_freed  <= n_freed;
            r_target <= n_target;
            if (i_cfg_valid) begin
                r_limit <= i_cfg_data;
            end
            if (emit) begin
                r_ovalid <= 1'b1;
            end else if (i_m_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Request and result payload registers.
    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_own  <= in_own;
            r_prio <= in_prio;
            r_sec  <= in_sec;
            r_n    <= in_n;
        end
        if (emit) begin
            r_okind <= e_kind;
            r_oown  <= e_own;
            r_osec  <= e_sec;
            r_ocnt  <= e_cnt;
            r_otot  <= n_cached;
            r_odw   <= n_wc;
            r_olast <= e_last;
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tuser  = r_okind;
    assign o_m_tlast  = r_olast;
    assign o_m_tdata  = {7'd0, r_odw, r_otot, r_ocnt, r_osec, r_oown};

endmodule
